// File: rtl/rgb_to_hsv_unit_assert.svh
// assertion macros used by the checker of the hsv converter
`ifndef RGB_TO_HSV_UNIT_ASSERT_SVH
`define RGB_TO_HSV_UNIT_ASSERT_SVH

// condition on the same edge implies the check on that edge
`define RHU_ASSERT_IMP(lbl, cond, chk) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (chk)) \
        else $error("rgb_to_hsv_unit: check failed");

// condition on one edge implies the check on the next edge
`define RHU_ASSERT_NXT(lbl, cond, chk) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) \
        else $error("rgb_to_hsv_unit: check failed");

`endif

// File: rtl/rgb2hsv_pkg.sv
`default_nettype none

package rgb2hsv_pkg;

    // channel and fixed point widths
    localparam int CH_W      = 8;
    localparam int FRAC_BITS = 16;
    localparam int HUE_W     = 16;
    localparam int SAT_W     = 17;

    // 6*max delta fits in DEN_W, signed hue numerator before wrap in NUM_W
    localparam int DEN_W = CH_W + 3;
    localparam int NUM_W = CH_W + 4;

    // quotient bits: one above the fraction so that 1.0 is representable
    localparam int QUO_W = FRAC_BITS + 1;

    // two front stages, one stage per quotient bit, one output stage
    localparam int LATENCY = 2 + QUO_W + 1;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue_out;
        logic [SAT_W-1:0] sat_out;
        logic [CH_W-1:0]  val_out;
    } hsv_t;

    // front end results handed to the dividers
    typedef struct packed {
        logic [DEN_W-1:0] hue_num;
        logic [DEN_W-1:0] hue_den;
        logic [CH_W-1:0]  delta;
        logic [CH_W-1:0]  mx;
        logic             zero;
    } prep_t;

endpackage

`default_nettype wire

// File: rtl/rgb_to_hsv_unit.sv
// rgb to hsv converter, fully pipelined
// an accepted start passes the front end, the quotient pipelines and the output register before the done strobe
// throughput: one item per cycle, set by the 17-stage quotient pipelines (one bit per stage)
// busy is held low: the pipeline never stalls and the receiver cannot hold results off
// reset clears all valid bits at once; no item is in flight afterwards
`default_nettype none

module rgb_to_hsv_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire rgb2hsv_pkg::pixel_t pixel,
    output logic                     done,
    output rgb2hsv_pkg::hsv_t        result
);
    import rgb2hsv_pkg::*;

    logic             prep_valid;
    prep_t            prep;
    logic [QUO_W-1:0] hue_quo;
    logic [QUO_W-1:0] sat_quo;

    logic             dly_valid_reg [QUO_W];
    logic [CH_W-1:0]  dly_val_reg [QUO_W];
    logic             dly_zero_reg [QUO_W];

    hsv_t             result_next;
    hsv_t             result_reg;
    logic             done_reg;

    assign busy = 1'b0;

    // front end: max, min, delta, hue numerator
    rgb2hsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .pixel     (pixel),
        .out_valid (prep_valid),
        .prep      (prep)
    );

    // hue = n / (6*delta)
    rgb2hsv_div u_hue_div (
        .clk (clk),
        .num (prep.hue_num),
        .den (prep.hue_den),
        .quo (hue_quo)
    );

    // saturation = delta / max
    rgb2hsv_div u_sat_div (
        .clk (clk),
        .num (DEN_W'(prep.delta)),
        .den (DEN_W'(prep.mx)),
        .quo (sat_quo)
    );

    // valid bits and side data alongside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                dly_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            dly_valid_reg[0] <= prep_valid;
            for (int i = 1; i < QUO_W; i++)
            begin
                dly_valid_reg[i] <= dly_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dly_val_reg[0]  <= prep.mx;
        dly_zero_reg[0] <= prep.zero;
        for (int i = 1; i < QUO_W; i++)
        begin
            dly_val_reg[i]  <= dly_val_reg[i-1];
            dly_zero_reg[i] <= dly_zero_reg[i-1];
        end
    end

    // grey or black forces hue and saturation to zero
    always_comb
    begin
        result_next.val_out = dly_val_reg[QUO_W-1];
        if (dly_zero_reg[QUO_W-1])
        begin
            result_next.hue_out = '0;
            result_next.sat_out = '0;
        end
        else
        begin
            result_next.hue_out = HUE_W'(hue_quo);
            result_next.sat_out = SAT_W'(sat_quo);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dly_valid_reg[QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/rgb2hsv_prep.sv
`default_nettype none

module rgb2hsv_prep (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire rgb2hsv_pkg::pixel_t pixel,
    output logic                     out_valid,
    output rgb2hsv_pkg::prep_t       prep
);
    import rgb2hsv_pkg::*;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } sel_t;

    logic [CH_W-1:0]         mx;
    logic [CH_W-1:0]         mn;
    sel_t                    sel;
    logic signed [CH_W:0]    diff;

    logic                    s1_valid_reg;
    logic [CH_W-1:0]         s1_mx_reg;
    logic [CH_W-1:0]         s1_mn_reg;
    sel_t                    s1_sel_reg;
    logic signed [CH_W:0]    s1_diff_reg;

    logic [CH_W-1:0]         delta;
    logic [NUM_W-1:0]        base;
    logic [DEN_W-1:0]        den6;
    logic signed [NUM_W-1:0] nraw;
    logic signed [NUM_W-1:0] nwrap;
    prep_t                   prep_next;

    logic                    s2_valid_reg;
    prep_t                   s2_prep_reg;

    // stage 1: max and min, strict compares so red beats green beats blue
    always_comb
    begin
        mn = pixel.red_in;
        if (pixel.green_in < mn)
        begin
            mn = pixel.green_in;
        end
        if (pixel.blue_in < mn)
        begin
            mn = pixel.blue_in;
        end
        mx  = pixel.red_in;
        sel = SEL_RED;
        if (pixel.green_in > mx)
        begin
            mx  = pixel.green_in;
            sel = SEL_GREEN;
        end
        if (pixel.blue_in > mx)
        begin
            mx  = pixel.blue_in;
            sel = SEL_BLUE;
        end
    end

    // channel difference for the winning sector
    always_comb
    begin
        unique case (sel)
            SEL_RED:
            begin
                diff = $signed({1'b0, pixel.green_in}) - $signed({1'b0, pixel.blue_in});
            end
            SEL_GREEN:
            begin
                diff = $signed({1'b0, pixel.blue_in}) - $signed({1'b0, pixel.red_in});
            end
            SEL_BLUE:
            begin
                diff = $signed({1'b0, pixel.red_in}) - $signed({1'b0, pixel.green_in});
            end
            default:
            begin
                diff = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mx_reg   <= mx;
        s1_mn_reg   <= mn;
        s1_sel_reg  <= sel;
        s1_diff_reg <= diff;
    end

    // stage 2: sector offset, wrap of negative numerator, 6*delta
    always_comb
    begin
        delta = s1_mx_reg - s1_mn_reg;
        unique case (s1_sel_reg)
            SEL_RED:
            begin
                base = '0;
            end
            SEL_GREEN:
            begin
                base = NUM_W'({delta, 1'b0});
            end
            SEL_BLUE:
            begin
                base = NUM_W'({delta, 2'b00});
            end
            default:
            begin
                base = '0;
            end
        endcase
        den6  = DEN_W'({delta, 2'b00}) + DEN_W'({delta, 1'b0});
        nraw  = $signed(base) + NUM_W'(s1_diff_reg);
        nwrap = nraw[NUM_W-1] ? nraw + $signed(NUM_W'(den6)) : nraw;

        prep_next.hue_num = nwrap[DEN_W-1:0];
        prep_next.hue_den = den6;
        prep_next.delta   = delta;
        prep_next.mx      = s1_mx_reg;
        prep_next.zero    = (delta == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_prep_reg <= prep_next;
    end

    assign out_valid = s2_valid_reg;
    assign prep      = s2_prep_reg;

endmodule

`default_nettype wire

// File: rtl/rgb2hsv_div.sv
`default_nettype none

// restoring divider, one quotient bit per stage: quo = floor(num * 2^FRAC_BITS / den)
// needs num <= den; the first stage settles the integer bit
module rgb2hsv_div (
    input  wire logic                            clk,
    input  wire logic [rgb2hsv_pkg::DEN_W-1:0]   num,
    input  wire logic [rgb2hsv_pkg::DEN_W-1:0]   den,
    output logic      [rgb2hsv_pkg::QUO_W-1:0]   quo
);
    import rgb2hsv_pkg::*;

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    logic             first_bit;
    logic [DEN_W-1:0] first_rem;

    // integer bit
    always_comb
    begin
        first_bit = (num >= den);
        first_rem = first_bit ? num - den : num;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= first_rem;
        den_reg[0] <= den;
        quo_reg[0] <= QUO_W'(first_bit);
    end

    // fraction bits, msb first
    for (genvar k = 1; k < QUO_W; k++)
    begin : g_stage
        logic [DEN_W:0] shifted;
        logic           take;

        assign shifted = {rem_reg[k-1], 1'b0};
        assign take    = (shifted >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= take ? DEN_W'(shifted - {1'b0, den_reg[k-1]})
                               : shifted[DEN_W-1:0];
            den_reg[k] <= den_reg[k-1];
            quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], take};
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/rgb2hsv_checker.sv
`default_nettype none
`include "rgb_to_hsv_unit_assert.svh"

module rgb2hsv_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire rgb2hsv_pkg::hsv_t   result
);
    import rgb2hsv_pkg::*;

    // saturation never exceeds 1.0
    `RHU_ASSERT_IMP(a_sat_range, done, result.sat_out <= SAT_W'(1 << FRAC_BITS))

    // a pixel with no saturation is grey and has no hue
    `RHU_ASSERT_IMP(a_grey_hue, done && (result.sat_out == '0), result.hue_out == '0)

    // black has no saturation (and, by the grey check, no hue)
    `RHU_ASSERT_IMP(a_black, done && (result.val_out == '0), result.sat_out == '0)

    // one result for each accepted item, a fixed latency later
    `RHU_ASSERT_IMP(a_latency, $past(rst_n, LATENCY), done == $past(start && !busy, LATENCY))

endmodule

bind rgb_to_hsv_unit rgb2hsv_checker u_rgb2hsv_checker (.*);

`default_nettype wire

// File: tb/tb_rgb_to_hsv_unit.sv
`timescale 1ns / 100ps

module tb_rgb_to_hsv_unit;

    import rgb2hsv_pkg::*;

    // which channel holds the maximum after the strict compares
    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } max_chan_t;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = LATENCY + 8;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    pixel_t pixel;
    logic   done;
    hsv_t   result;

    hsv_t pending_hsv[$];
    int   error_count;
    int   cycle_count;
    bit   idle_on;

    rgb_to_hsv_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .result (result)
    );

    // free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // fixed point hsv of one pixel
    function automatic hsv_t compute_hsv(input pixel_t p);
        int r;
        int g;
        int b;
        int top;
        int bottom;
        int spread;
        int num;
        max_chan_t winner;
        longint unsigned hue_q;
        longint unsigned sat_q;
        hsv_t res;
        r = p.red_in;
        g = p.green_in;
        b = p.blue_in;
        bottom = r;
        if (g < bottom) bottom = g;
        if (b < bottom) bottom = b;
        top = r;
        winner = CH_RED;
        if (g > top)
        begin
            top = g;
            winner = CH_GREEN;
        end
        if (b > top)
        begin
            top = b;
            winner = CH_BLUE;
        end
        spread = top - bottom;
        hue_q = 0;
        sat_q = 0;
        if (spread != 0)
        begin
            case (winner)
                CH_RED:   num = g - b;
                CH_GREEN: num = 2 * spread + (b - r);
                default:  num = 4 * spread + (r - g);
            endcase
            // wrap negative hue into the full turn
            if (num < 0) num += 6 * spread;
            hue_q = (longint'(num) << FRAC_BITS) / longint'(6 * spread);
            sat_q = (longint'(spread) << FRAC_BITS) / longint'(top);
        end
        res.hue_out = hue_q[HUE_W-1:0];
        res.sat_out = sat_q[SAT_W-1:0];
        res.val_out = top[CH_W-1:0];
        return res;
    endfunction

    function automatic pixel_t make_pixel(input int r, input int g, input int b);
        pixel_t p;
        p.red_in   = r[CH_W-1:0];
        p.green_in = g[CH_W-1:0];
        p.blue_in  = b[CH_W-1:0];
        return p;
    endfunction

    // random pixel, biased toward ties, greys, zeros and extremes
    function automatic pixel_t random_pixel();
        int kind;
        int r;
        int g;
        int b;
        int lvl;
        kind = $urandom_range(0, 9);
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        lvl = $urandom_range(0, 255);
        case (kind)
            0: begin
                r = lvl; g = lvl; b = lvl;
            end
            1: begin
                // two channels tied, possibly at the maximum
                case ($urandom_range(0, 2))
                    0: g = r;
                    1: b = g;
                    default: b = r;
                endcase
            end
            2: begin
                case ($urandom_range(0, 2))
                    0: r = 0;
                    1: g = 0;
                    default: b = 0;
                endcase
            end
            3: begin
                r = $urandom_range(0, 1) ? 255 : 0;
                g = $urandom_range(0, 1) ? 255 : 0;
                b = $urandom_range(0, 1) ? 255 : 0;
            end
            4: begin
                // small spread near one level
                r = lvl;
                g = (lvl + $urandom_range(0, 2)) % 256;
                b = (lvl + $urandom_range(0, 2)) % 256;
            end
            default: ;
        endcase
        return make_pixel(r, g, b);
    endfunction

    // send one item, entered and left at a falling edge
    task automatic send_pixel(input pixel_t p);
        start <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        pending_hsv.push_back(compute_hsv(p));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // random idle burst between items
    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 6));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_hsv.size() != 0) @(negedge clk);
    endtask

    // corner pixels: greys, primaries, ties, hue wrap, unit spread
    task automatic test_directed();
        pixel_t list[$];
        list.push_back(make_pixel(0, 0, 0));
        list.push_back(make_pixel(255, 255, 255));
        list.push_back(make_pixel(128, 128, 128));
        list.push_back(make_pixel(255, 0, 0));
        list.push_back(make_pixel(0, 255, 0));
        list.push_back(make_pixel(0, 0, 255));
        list.push_back(make_pixel(255, 255, 0));
        list.push_back(make_pixel(0, 255, 255));
        list.push_back(make_pixel(255, 0, 255));
        list.push_back(make_pixel(255, 0, 1));
        list.push_back(make_pixel(200, 10, 100));
        list.push_back(make_pixel(10, 200, 100));
        list.push_back(make_pixel(100, 10, 200));
        list.push_back(make_pixel(1, 0, 0));
        list.push_back(make_pixel(0, 1, 1));
        list.push_back(make_pixel(255, 254, 254));
        list.push_back(make_pixel(254, 255, 254));
        list.push_back(make_pixel(254, 254, 255));
        list.push_back(make_pixel(1, 1, 0));
        list.push_back(make_pixel(255, 128, 0));
        list.push_back(make_pixel(170, 85, 255));
        list.push_back(make_pixel(85, 170, 0));
        idle_on = 1'b1;
        foreach (list[i])
        begin
            send_pixel(list[i]);
            maybe_idle();
        end
    endtask

    // random pixels with idle bursts in stretches
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            // each stretch of 64 items idles or not, chosen at random
            if (i % 64 == 0) idle_on = $urandom_range(0, 2) != 0;
            send_pixel(random_pixel());
            maybe_idle();
        end
    endtask

    // sender stops until the pipeline has fully emptied, then resumes
    task automatic test_drain_pause(input int rounds);
        idle_on = 1'b1;
        for (int k = 0; k < rounds; k++)
        begin
            repeat ($urandom_range(1, 25))
            begin
                send_pixel(random_pixel());
                maybe_idle();
            end
            wait_drained();
        end
    endtask

    // back to back items, no idling; the caller drops start afterwards
    task automatic test_full_rate(input int count);
        idle_on = 1'b0;
        repeat (count) send_pixel(random_pixel());
    endtask

    // check each result against the oldest expected hsv
    always @(posedge clk)
    begin
        hsv_t want;
        if (rst_n && done)
        begin
            if (pending_hsv.size() == 0)
            begin
                $error("result with no item outstanding");
                error_count++;
            end
            else
            begin
                want = pending_hsv.pop_front();
                if (result.hue_out !== want.hue_out)
                begin
                    $error("hue_out: expected %0d, actual %0d", want.hue_out, result.hue_out);
                    error_count++;
                end
                if (result.sat_out !== want.sat_out)
                begin
                    $error("sat_out: expected %0d, actual %0d", want.sat_out, result.sat_out);
                    error_count++;
                end
                if (result.val_out !== want.val_out)
                begin
                    $error("val_out: expected %0d, actual %0d", want.val_out, result.val_out);
                    error_count++;
                end
            end
        end
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_rgb_to_hsv_unit: done, errors");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        error_count = 0;
        cycle_count = 0;
        idle_on = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random(560);
        test_drain_pause(8);
        test_full_rate(260);

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (error_count == 0)
            $display("tb_rgb_to_hsv_unit: done, clean");
        else
            $display("tb_rgb_to_hsv_unit: done, errors");
        $finish;
    end

endmodule

// File: rgb_to_hsv_unit.f
+incdir+rtl
rtl/rgb2hsv_pkg.sv
rtl/rgb2hsv_prep.sv
rtl/rgb2hsv_div.sv
rtl/rgb_to_hsv_unit.sv
rtl/rgb2hsv_checker.sv
tb/tb_rgb_to_hsv_unit.sv
